// ===== src/integer_to_radix_ascii_unit_defines.svh =====
// assertion macros shared by the radix ascii unit
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ITOA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itoa assertion failed");

// next-cycle implication, disabled during reset
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itoa assertion failed");

`endif

// ===== src/itoa_pkg.sv =====
// shared types and constants of the radix ascii unit
`default_nettype none

package itoa_pkg;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_MINUS   = 8'h2D;

   localparam logic [4:0] RADIX_MIN   = 5'd2;
   localparam logic [4:0] RADIX_MAX   = 5'd16;
   localparam logic [4:0] RADIX_RESET = 5'd10;

   // bits of the quotient retired per divider cycle
   localparam int BITS_PER_STEP = 4;

   typedef struct packed {
      logic load;        // take the input item, start a new string
      logic div_step;    // one divider cycle
      logic emit_sign;   // put '-' into the output register
      logic emit_digit;  // pop one digit into the output register
   } itoa_cmd_type;

   typedef struct packed {
      logic step_last;   // this divider cycle finishes a digit
      logic quot_zero;   // quotient after this cycle is zero
      logic out_free;    // output register can take a character
      logic neg;         // minus sign still to be sent
      logic count_one;   // one digit left on the stack
   } itoa_sts_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      if (d >= 4'd10) begin
         digit_char = CH_UPPER_A + {4'd0, d} - 8'd10;
      end else begin
         digit_char = CH_ZERO + {4'd0, d};
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/itoa_ctrl.sv =====
// controller state machine of the radix ascii unit
`default_nettype none

module itoa_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire itoa_pkg::itoa_sts_type sts,
   output itoa_pkg::itoa_cmd_type cmd
);
   import itoa_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.step_last && sts.quot_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               if (sts.neg) begin
                  cmd.emit_sign = 1'b1;
               end else begin
                  cmd.emit_digit = 1'b1;
                  if (sts.count_one) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/itoa_datapath.sv =====
// divider, digit stack, radix register and output register
`default_nettype none

module itoa_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire [VALUE_WIDTH-1:0]   req_value,
   input  wire                     req_is_signed,
   input  wire                     csr_we,
   input  wire [4:0]               csr_wdata,
   input  wire itoa_pkg::itoa_cmd_type cmd,
   output itoa_pkg::itoa_sts_type  sts,
   input  wire                     rsp_ready,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_char_code,
   output logic                    rsp_last
);
   import itoa_pkg::*;

   localparam int STEPS   = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_W   = STEPS * BITS_PER_STEP;
   localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
   localparam int STACK_W = VALUE_WIDTH * 4;

   logic [4:0]          radix_ff;
   logic [4:0]          base;
   logic [PAD_W-1:0]    quo_ff;
   logic [PAD_W-1:0]    quo_in;
   logic [3:0]          rem_ff;
   logic [3:0]          rem_in;
   logic [STEP_W-1:0]   step_ff;
   logic                step_last;
   logic                neg_ff;
   logic [STACK_W-1:0]  stack_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_char_ff;
   logic                rsp_last_ff;
   logic                is_neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic                out_free;

   // clamp the radix into 2..16
   always_comb begin
      if (radix_ff inside {[RADIX_MIN:RADIX_MAX]}) begin
         base = radix_ff;
      end else if (radix_ff < RADIX_MIN) begin
         base = RADIX_MIN;
      end else begin
         base = RADIX_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_we) begin
         radix_ff <= csr_wdata;
      end
   end

   assign is_neg = req_is_signed && req_value[VALUE_WIDTH-1];
   assign mag    = is_neg ? (~req_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : req_value;

   // restoring division, four quotient bits per cycle
   always_comb begin
      logic [4:0]       r;
      logic [PAD_W-1:0] q;
      r = {1'b0, rem_ff};
      q = quo_ff;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         r = {r[3:0], q[PAD_W-1]};
         q = {q[PAD_W-2:0], 1'b0};
         if (r >= base) begin
            r    = r - base;
            q[0] = 1'b1;
         end
      end
      rem_in = r[3:0];
      quo_in = q;
   end

   assign step_last = (step_ff == STEP_W'(STEPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quo_ff   <= PAD_W'(mag);
         rem_ff   <= 4'd0;
         step_ff  <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         if (step_last) begin
            rem_ff   <= 4'd0;
            step_ff  <= '0;
            stack_ff <= {stack_ff[STACK_W-5:0], rem_in};
         end else begin
            rem_ff  <= rem_in;
            step_ff <= step_ff + STEP_W'(1);
         end
      end else if (cmd.emit_digit) begin
         stack_ff <= {4'd0, stack_ff[STACK_W-1:4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (cmd.load) begin
         neg_ff <= is_neg;
         cnt_ff <= '0;
      end else begin
         if (cmd.emit_sign) begin
            neg_ff <= 1'b0;
         end
         if (cmd.div_step && step_last) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cmd.emit_digit) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_char_ff <= CH_MINUS;
         rsp_last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_char_ff <= digit_char(stack_ff[3:0]);
         rsp_last_ff <= (cnt_ff == CNT_W'(1));
      end
   end

   assign sts.step_last = step_last;
   assign sts.quot_zero = (quo_in == '0);
   assign sts.out_free  = out_free;
   assign sts.neg       = neg_ff;
   assign sts.count_one = (cnt_ff == CNT_W'(1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/integer_to_radix_ascii_unit.sv =====
// top level of the integer to radix ascii unit
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_ready  | req_value, req_is_signed
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_char_code, rsp_last
//   csr     | in        | csr_we, no wait      | csr_wdata (radix)
//
// one item: accept, then a full divider pass over the value per digit,
//   then sign and digits into the output register as the output side takes them
// a 32-bit decimal item has at most 10 digits and 11 characters
// the divider retires four quotient bits a cycle
// reset: synchronous, radix back to 10, output empty, controller idle
// a stalled rsp side holds the emit phase; req_ready is high only when idle
`default_nettype none

module integer_to_radix_ascii_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   // input items
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire [VALUE_WIDTH-1:0] req_value,
   input  wire                   req_is_signed,
   // result items
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last,
   // radix register
   input  wire                   csr_we,
   input  wire [4:0]             csr_wdata
);
   import itoa_pkg::*;

`include "integer_to_radix_ascii_unit_defines.svh"

   itoa_cmd_type cmd;
   itoa_sts_type sts;

   // sequencing: idle -> divide per digit -> emit sign and digits
   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // divider, digit stack (lsd pushed first, popped msd first), output register
   itoa_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   // a new item is only taken while idle, so ready drops right after
   `ITOA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // only legal characters leave the block
   `ITOA_ASSERT_SAME(a_char_legal, clock, reset, rsp_valid,
      (rsp_char_code == CH_MINUS) ||
      ((rsp_char_code >= CH_ZERO) && (rsp_char_code <= CH_NINE)) ||
      ((rsp_char_code >= CH_UPPER_A) && (rsp_char_code <= CH_UPPER_F)))

   // a sign never ends a string
   `ITOA_ASSERT_SAME(a_sign_not_last, clock, reset,
      rsp_valid && (rsp_char_code == CH_MINUS), !rsp_last)

endmodule

`default_nettype wire
